FILE: rtl/gmf_pkg.sv
package gmf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_KERNEL = 7;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 11;

    typedef enum logic [CFG_AW-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_KERNEL_WIDTH  = 2'd2,
        REG_KERNEL_HEIGHT = 2'd3
    } gmf_reg_t;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic [CFG_DW-1:0] RST_IMAGE_WIDTH   = 11'd1024;
    localparam logic [CFG_DW-1:0] RST_IMAGE_HEIGHT  = 11'd1024;
    localparam logic [2:0]        RST_KERNEL_WIDTH  = 3'd3;
    localparam logic [2:0]        RST_KERNEL_HEIGHT = 3'd3;

    // position and frame flag that travel with a window through the sorter
    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic       frame_end;
    } gmf_tag_t;

endpackage

FILE: rtl/grayscale_median_filter_unit.sv
// Streaming median filter for 8-bit gray images, raster order in and out. Every
// clock takes one item (a pixel, or a drain tick after the last pixel of a frame)
// unless the output stalls, so the sustained rate is one item per cycle while the
// output is not stalled. A result passes through one input register, one window
// register and the chain of compare-exchange cells that sorts the full
// MAX_KERNEL x MAX_KERNEL window, one layer per cell, plus the output register.
// Lines are held in MAX_KERNEL-1 line RAMs of MAX_WIDTH pixels, read once and
// written once per item. Unused window slots are padded with white, border pixels
// read as zero.
// Outputs trail inputs by (kernel_height-1-kernel_height/2) lines plus
// (kernel_width-1-kernel_width/2) pixels; send that many drain ticks after a
// frame to flush them. A stall on the output holds the whole pipeline. Write the
// registers only while idle; a write restarts the frame. No clearing pass.
module grayscale_median_filter_unit
    import gmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [7:0]        pixel_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        pixel_out,
    output logic [9:0]        out_row,
    output logic [9:0]        out_col,
    output logic              frame_end,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam int K  = MAX_KERNEL;
    localparam int NN = K * K;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + MAX_KERNEL + 1);
    localparam int KW = $clog2(MAX_KERNEL + 1);
    localparam int MW = 2 * KW;
    localparam int IW = $clog2(NN);
    localparam int PW = CW + 4;

    // configuration
    logic [CFG_DW-1:0] img_w_reg, img_h_reg;
    logic [2:0]        ker_w_reg, ker_h_reg;
    logic [CW:0]       w_eff;
    logic [RW-1:0]     h_eff;
    logic [KW-1:0]     kw_eff, kh_eff, hi, hj;
    logic [PW-1:0]     delay;
    logic [MW-1:0]     mid;

    // input side counters
    logic [RW-1:0] in_row_reg, out_row_reg;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [PW-1:0] pend_reg;

    logic          en, acc, is_pix, frame_done, clr, emit, move;
    logic [RW-1:0] b_in_row, b_orow, in_row_next, orow_next;
    logic [CW-1:0] b_in_col, b_ocol, in_col_next, ocol_next;
    logic [PW-1:0] b_pend, p1, pend_next;
    logic          fe_now;

    // stage 1
    logic              s1_valid_reg, s1_emit_reg, fwd_reg;
    logic [7:0]        s1_pix_reg;
    logic [CW-1:0]     s1_col_reg, s1_ocol_reg;
    logic [RW-1:0]     s1_orow_reg;
    gmf_tag_t          s1_tag_reg;
    logic [K-2:0][7:0] fwd_data_reg;
    logic [K-2:0][7:0] ram_q;
    logic [K-1:0][7:0] s1_stack;
    logic [K-1:0]      row_use, row_in, col_use, col_in;
    logic              rd_en, we;

    // window and stage 2
    logic [K-1:0][K-1:0][7:0] win_reg;
    logic                     s2_valid_reg;
    gmf_tag_t                 s2_tag_reg;
    logic [K-1:0]             s2_row_use_reg, s2_row_in_reg, s2_col_use_reg, s2_col_in_reg;

    // sort chain
    logic     [NN:0]               c_valid;
    logic     [NN:0][NN-1:0][7:0]  c_vals;
    gmf_tag_t                      c_tag [NN+1];

    // output
    logic       out_valid_reg;
    logic [7:0] pixel_out_reg;
    gmf_tag_t   out_tag_reg;

    always_comb
    begin
        if (img_w_reg == '0)
            w_eff = (CW+1)'(1);
        else if (32'(img_w_reg) > MAX_WIDTH)
            w_eff = (CW+1)'(MAX_WIDTH);
        else
            w_eff = (CW+1)'(img_w_reg);

        if (img_h_reg == '0)
            h_eff = RW'(1);
        else if (32'(img_h_reg) > MAX_HEIGHT)
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(img_h_reg);

        if (ker_w_reg == '0)
            kw_eff = KW'(1);
        else if (32'(ker_w_reg) > MAX_KERNEL)
            kw_eff = KW'(MAX_KERNEL);
        else
            kw_eff = KW'(ker_w_reg);

        if (ker_h_reg == '0)
            kh_eff = KW'(1);
        else if (32'(ker_h_reg) > MAX_KERNEL)
            kh_eff = KW'(MAX_KERNEL);
        else
            kh_eff = KW'(ker_h_reg);

        hi    = kh_eff - KW'(1) - (kh_eff >> 1);
        hj    = kw_eff - KW'(1) - (kw_eff >> 1);
        delay = PW'(hi) * PW'(w_eff) + PW'(hj);
        mid   = (MW'(kw_eff) * MW'(kh_eff)) >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= RST_IMAGE_WIDTH;
            img_h_reg <= RST_IMAGE_HEIGHT;
            ker_w_reg <= RST_KERNEL_WIDTH;
            ker_h_reg <= RST_KERNEL_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            case (gmf_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:   img_w_reg <= cfg_data;
                REG_IMAGE_HEIGHT:  img_h_reg <= cfg_data;
                REG_KERNEL_WIDTH:  ker_w_reg <= cfg_data[2:0];
                REG_KERNEL_HEIGHT: ker_h_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;
    assign acc      = in_valid && en;

    // decide whether this item moves the stream and whether it releases a result
    always_comb
    begin
        is_pix     = (kind == KIND_PIXEL);
        frame_done = (in_row_reg >= h_eff);
        clr        = is_pix && frame_done;
        b_in_row   = clr ? '0 : in_row_reg;
        b_in_col   = clr ? '0 : in_col_reg;
        b_orow     = clr ? '0 : out_row_reg;
        b_ocol     = clr ? '0 : out_col_reg;
        b_pend     = clr ? '0 : pend_reg;
        p1         = b_pend + PW'(1);

        if (is_pix)
        begin
            emit = (b_orow < h_eff) && (p1 > delay);
            move = 1'b1;
        end
        else
        begin
            emit = frame_done && (out_row_reg < h_eff);
            move = emit;
        end

        pend_next = is_pix ? (p1 - PW'(emit)) : pend_reg;

        if (({1'b0, b_in_col} + (CW+1)'(1)) >= w_eff)
        begin
            in_col_next = '0;
            in_row_next = b_in_row + RW'(1);
        end
        else
        begin
            in_col_next = b_in_col + CW'(1);
            in_row_next = b_in_row;
        end

        if (({1'b0, b_ocol} + (CW+1)'(1)) >= w_eff)
        begin
            ocol_next = '0;
            orow_next = b_orow + RW'(1);
        end
        else
        begin
            ocol_next = b_ocol + CW'(1);
            orow_next = b_orow;
        end

        fe_now = (b_orow == h_eff - RW'(1)) && ({1'b0, b_ocol} == w_eff - (CW+1)'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            pend_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            pend_reg    <= '0;
        end
        else if (acc && move)
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            pend_reg   <= pend_next;
            if (emit)
            begin
                out_row_reg <= orow_next;
                out_col_reg <= ocol_next;
            end
            else
            begin
                out_row_reg <= b_orow;
                out_col_reg <= b_ocol;
            end
        end
    end

    // line RAM cascade: RAM k holds the line k+1 above the newest one
    assign rd_en = acc && move;
    assign we    = s1_valid_reg && en;

    for (genvar g = 0; g < K - 1; g++)
    begin : g_line
        gmf_ram #(
            .WIDTH (8),
            .DEPTH (MAX_WIDTH)
        ) u_line_ram (
            .clk     (clk),
            .wr_en   (we),
            .wr_addr (s1_col_reg),
            .wr_data (s1_stack[g]),
            .rd_en   (rd_en),
            .rd_addr (b_in_col),
            .rd_data (ram_q[g])
        );
    end

    always_comb
    begin
        s1_stack[0] = s1_pix_reg;
        for (int k = 1; k < K; k++)
        begin
            s1_stack[k] = fwd_reg ? fwd_data_reg[k-1] : ram_q[k-1];
        end
    end

    // border masks for the output position carried in stage 1
    always_comb
    begin
        logic [RW:0] ty;
        logic [CW:0] tx;
        ty = {1'b0, s1_orow_reg} + (RW+1)'(hi);
        tx = {1'b0, s1_ocol_reg} + (CW+1)'(hj);
        for (int k = 0; k < K; k++)
        begin
            row_use[k] = (KW'(k) < kh_eff);
            row_in[k]  = (ty >= (RW+1)'(k)) && ((ty - (RW+1)'(k)) < {1'b0, h_eff});
            col_use[k] = (KW'(k) < kw_eff);
            col_in[k]  = (tx >= (CW+1)'(k)) && ((tx - (CW+1)'(k)) < w_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= acc && move;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            // same address written and read at one edge: take the written column
            if (rd_en)
            begin
                fwd_reg <= we && (s1_col_reg == b_in_col);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && rd_en)
        begin
            fwd_data_reg <= s1_stack[K-2:0];
            s1_emit_reg  <= emit;
            s1_pix_reg   <= is_pix ? pixel_in : 8'd0;
            s1_col_reg   <= b_in_col;
            s1_orow_reg  <= b_orow;
            s1_ocol_reg  <= b_ocol;
            s1_tag_reg   <= '{row: 10'(b_orow), col: 10'(b_ocol), frame_end: fe_now};
        end
        if (we)
        begin
            win_reg[0] <= s1_stack;
            for (int j = 1; j < K; j++)
            begin
                win_reg[j] <= win_reg[j-1];
            end
            s2_tag_reg     <= s1_tag_reg;
            s2_row_use_reg <= row_use;
            s2_row_in_reg  <= row_in;
            s2_col_use_reg <= col_use;
            s2_col_in_reg  <= col_in;
        end
    end

    // pad unused slots white so the median sits at index n/2 of the full sort
    always_comb
    begin
        for (int k = 0; k < K; k++)
        begin
            for (int j = 0; j < K; j++)
            begin
                if (!(s2_row_use_reg[k] && s2_col_use_reg[j]))
                    c_vals[0][k*K+j] = 8'hFF;
                else if (s2_row_in_reg[k] && s2_col_in_reg[j])
                    c_vals[0][k*K+j] = win_reg[j][k];
                else
                    c_vals[0][k*K+j] = 8'd0;
            end
        end
    end

    assign c_valid[0] = s2_valid_reg;
    assign c_tag[0]   = s2_tag_reg;

    for (genvar g = 0; g < NN; g++)
    begin : g_sort
        gmf_sort_cell #(
            .NUM   (NN),
            .PHASE (1'(g % 2))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c_valid[g]),
            .in_vals   (c_vals[g]),
            .in_tag    (c_tag[g]),
            .out_valid (c_valid[g+1]),
            .out_vals  (c_vals[g+1]),
            .out_tag   (c_tag[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c_valid[NN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && c_valid[NN])
        begin
            pixel_out_reg <= c_vals[NN][mid[IW-1:0]];
            out_tag_reg   <= c_tag[NN];
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign out_row   = out_tag_reg.row;
    assign out_col   = out_tag_reg.col;
    assign frame_end = out_tag_reg.frame_end;

endmodule

FILE: rtl/gmf_ram.sv
module gmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/gmf_sort_cell.sv
module gmf_sort_cell
    import gmf_pkg::*;
#(
    parameter int NUM   = DEF_MAX_KERNEL * DEF_MAX_KERNEL,
    parameter bit PHASE = 1'b0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [NUM-1:0][7:0]     in_vals,
    input  gmf_tag_t                in_tag,
    output logic                    out_valid,
    output logic [NUM-1:0][7:0]     out_vals,
    output gmf_tag_t                out_tag
);

    logic              valid_reg;
    logic [NUM-1:0][7:0] vals_reg;
    gmf_tag_t          tag_reg;
    logic [NUM-1:0][7:0] vals_next;

    // one compare-exchange layer of an odd-even transposition sort
    always_comb
    begin
        vals_next = in_vals;
        for (int i = int'(PHASE); i + 1 < NUM; i += 2)
        begin
            if (in_vals[i] > in_vals[i+1])
            begin
                vals_next[i]   = in_vals[i+1];
                vals_next[i+1] = in_vals[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            vals_reg <= vals_next;
            tag_reg  <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_vals  = vals_reg;
    assign out_tag   = tag_reg;

endmodule

FILE: rtl/gmf_checker.sv
module gmf_checker
    import gmf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              kind,
    input logic [7:0]        pixel_in,
    input logic              out_valid,
    input logic              out_stall,
    input logic [7:0]        pixel_out,
    input logic [9:0]        out_row,
    input logic [9:0]        out_col,
    input logic              frame_end,
    input logic              cfg_wr_en,
    input logic [CFG_AW-1:0] cfg_index,
    input logic [CFG_DW-1:0] cfg_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(out_row)
            && $stable(out_col) && $stable(frame_end))
        else $error("stalled result changed");

    // the input backs up only behind a result that waits
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a new result appears only after the pipeline advanced
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_stall))
        else $error("result appeared while pipeline held");

endmodule

bind grayscale_median_filter_unit gmf_checker u_gmf_checker (.*);

FILE: dv/grayscale_median_filter_unit_tb.sv
`timescale 1ns / 100ps

module grayscale_median_filter_unit_tb;
    import gmf_pkg::*;

    localparam int LINE_LEN    = DEF_MAX_WIDTH;
    localparam int RING        = DEF_MAX_KERNEL + 1;
    localparam int PIPE_DEPTH  = DEF_MAX_KERNEL * DEF_MAX_KERNEL + 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] pix;
        logic [9:0] row;
        logic [9:0] col;
        logic       fend;
    } median_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              kind;
    logic [7:0]        pixel_in;
    logic              out_valid;
    logic              out_stall;
    logic [7:0]        pixel_out;
    logic [9:0]        out_row;
    logic [9:0]        out_col;
    logic              frame_end;
    logic              cfg_wr_en;
    logic [CFG_AW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    // filter image copy kept by the testbench
    logic [7:0]  line_ring [RING*LINE_LEN];
    logic [10:0] img_w_reg, img_h_reg;
    logic [2:0]  ker_w_reg, ker_h_reg;
    int unsigned in_row_n, in_col_n, out_row_n, out_col_n;

    median_t     pending_medians[$];
    bit          failed;
    bit          quiet;
    int unsigned items_sent;
    int unsigned cycle_n;

    grayscale_median_filter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .out_row   (out_row),
        .out_col   (out_col),
        .frame_end (frame_end),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic int unsigned eff_w();
        return clamp_dim(32'(img_w_reg), DEF_MAX_WIDTH);
    endfunction

    function automatic int unsigned eff_h();
        return clamp_dim(32'(img_h_reg), DEF_MAX_HEIGHT);
    endfunction

    function automatic int unsigned eff_kw();
        return clamp_dim(32'(ker_w_reg), DEF_MAX_KERNEL);
    endfunction

    function automatic int unsigned eff_kh();
        return clamp_dim(32'(ker_h_reg), DEF_MAX_KERNEL);
    endfunction

    // outputs still owed once the last pixel of a frame is in
    function automatic int unsigned trail_len();
        int unsigned kh;
        int unsigned kw;
        kh = eff_kh();
        kw = eff_kw();
        return (kh - 1 - kh / 2) * eff_w() + (kw - 1 - kw / 2);
    endfunction

    task automatic push_median();
        int          w;
        int          h;
        int          kw;
        int          kh;
        int          y;
        int          x;
        int          n;
        int          j;
        logic [7:0]  win[DEF_MAX_KERNEL*DEF_MAX_KERNEL];
        logic [7:0]  key;
        median_t     m;
        w = eff_w();
        h = eff_h();
        kw = eff_kw();
        kh = eff_kh();
        n = 0;
        for (int ty = 0; ty < kh; ty++)
        begin
            y = int'(out_row_n) - kh / 2 + ty;
            for (int tx = 0; tx < kw; tx++)
            begin
                x = int'(out_col_n) - kw / 2 + tx;
                if (y >= 0 && y < h && x >= 0 && x < w)
                    win[n] = line_ring[(y % RING) * LINE_LEN + x];
                else
                    win[n] = 8'd0;
                n++;
            end
        end
        for (int i = 1; i < n; i++)
        begin
            key = win[i];
            j = i;
            while (j > 0 && win[j-1] > key)
            begin
                win[j] = win[j-1];
                j--;
            end
            win[j] = key;
        end
        m.pix  = win[n/2];
        m.row  = out_row_n[9:0];
        m.col  = out_col_n[9:0];
        m.fend = (out_row_n == h - 1 && out_col_n == w - 1);
        pending_medians.insert(pending_medians.size(), m);
        out_col_n++;
        if (out_col_n >= w)
        begin
            out_col_n = 0;
            out_row_n++;
        end
    endtask

    task automatic advance_filter(logic k, logic [7:0] p);
        int unsigned w;
        int unsigned h;
        w = eff_w();
        h = eff_h();
        if (k == KIND_PIXEL)
        begin
            if (in_row_n >= h)
            begin
                in_row_n = 0;
                in_col_n = 0;
                out_row_n = 0;
                out_col_n = 0;
            end
            line_ring[(in_row_n % RING) * LINE_LEN + in_col_n] = p;
            in_col_n++;
            if (in_col_n >= w)
            begin
                in_col_n = 0;
                in_row_n++;
            end
            if (out_row_n < h &&
                out_row_n * w + out_col_n + trail_len() + 1 <= in_row_n * w + in_col_n)
                push_median();
        end
        else if (in_row_n >= h && out_row_n < h)
            push_median();
    endtask

    // hold the item until a transfer, then maybe leave a gap with valid low
    task automatic send_item(logic k, logic [7:0] p);
        bit go;
        in_valid <= 1'b1;
        kind     <= k;
        pixel_in <= p;
        forever
        begin
            @(negedge clk);
            go = !in_stall;
            @(posedge clk);
            if (go)
                break;
        end
        advance_filter(k, p);
        items_sent++;
        if (!quiet && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            kind     <= 1'($urandom_range(1));
            pixel_in <= 8'($urandom_range(255));
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 16) @(posedge clk);
    endtask

    task automatic write_reg(gmf_reg_t idx, int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DW-1:0];
        @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:   img_w_reg = val[10:0];
            REG_IMAGE_HEIGHT:  img_h_reg = val[10:0];
            REG_KERNEL_WIDTH:  ker_w_reg = val[2:0];
            default:           ker_h_reg = val[2:0];
        endcase
        in_row_n = 0;
        in_col_n = 0;
        out_row_n = 0;
        out_col_n = 0;
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned kw,
                                int unsigned kh);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_KERNEL_WIDTH, kw);
        write_reg(REG_KERNEL_HEIGHT, kh);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_frame(int unsigned npix, int unsigned ndrain);
        for (int unsigned i = 0; i < npix; i++)
            send_item(KIND_PIXEL, 8'($urandom_range(255)));
        for (int unsigned i = 0; i < ndrain; i++)
            send_item(KIND_DRAIN, 8'($urandom_range(255)));
    endtask

    task automatic test_small_frame();
        logic [7:0] pat[12] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd1,
                                8'd254, 8'd127, 8'd255, 8'd255, 8'd0, 8'd85};
        set_geometry(4, 3, 3, 3);
        send_item(KIND_DRAIN, 8'd0);
        foreach (pat[i])
            send_item(KIND_PIXEL, pat[i]);
        send_frame(0, trail_len() + 2);
        // pixel after a complete frame opens a new one; drain mid-frame is a no-op
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_DRAIN, 8'd255);
        send_item(KIND_PIXEL, 8'd0);
    endtask

    task automatic test_kernel_shapes();
        set_geometry(5, 2, 0, 7);
        send_frame(10, trail_len() + 1);
        set_geometry(3, 3, 2, 4);
        send_frame(9, trail_len());
        set_geometry(0, 0, 7, 7);
        send_frame(1, trail_len() + 1);
    endtask

    task automatic test_full_width();
        // part of one line at the clamped width, columns well past eight bits
        set_geometry(2047, 1, 7, 1);
        send_frame(300, 0);
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned npix;
        int unsigned frames;
        frames = 0;
        while (items_sent < 1050)
        begin
            quiet = (frames >= 3 && frames < 9);
            if (frames % 3 == 0)
            begin
                w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                h = $urandom_range(1, 8);
                set_geometry(w, h, $urandom_range(7), $urandom_range(7));
            end
            npix = eff_w() * eff_h();
            case ($urandom_range(9))
                0:
                begin
                    // broken frame: may stop short, drains then find nothing
                    send_frame($urandom_range(npix), $urandom_range(3));
                end
                1:
                begin
                    // stray drain ticks mid-frame
                    send_frame(npix / 2, 2);
                    send_frame(npix - npix / 2, trail_len());
                end
                2:
                begin
                    // may cut the drain short, next frame drops the rest
                    send_frame(npix, $urandom_range(trail_len()));
                end
                default:
                begin
                    send_frame(npix, trail_len() + $urandom_range(2));
                end
            endcase
            frames++;
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        median_t m;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_medians.size() == 0)
            begin
                $display("%0t: unexpected result pixel %0d row %0d col %0d", $time,
                         pixel_out, out_row, out_col);
                failed = 1'b1;
            end
            else
            begin
                m = pending_medians.pop_front();
                if (pixel_out !== m.pix)
                begin
                    $display("%0t: pixel_out expected %0d actual %0d", $time, m.pix, pixel_out);
                    failed = 1'b1;
                end
                if (out_row !== m.row)
                begin
                    $display("%0t: out_row expected %0d actual %0d", $time, m.row, out_row);
                    failed = 1'b1;
                end
                if (out_col !== m.col)
                begin
                    $display("%0t: out_col expected %0d actual %0d", $time, m.col, out_col);
                    failed = 1'b1;
                end
                if (frame_end !== m.fend)
                begin
                    $display("%0t: frame_end expected %0d actual %0d", $time, m.fend,
                             frame_end);
                    failed = 1'b1;
                end
            end
        end
        out_stall <= !quiet && ($urandom_range(99) < 14);
    end

    always @(posedge clk)
    begin
        cycle_n <= cycle_n + 1;
        if (cycle_n > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_PIXEL;
        pixel_in  = 8'd0;
        out_stall = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        failed    = 1'b0;
        quiet     = 1'b0;
        cycle_n   = 0;
        items_sent = 0;
        img_w_reg = RST_IMAGE_WIDTH;
        img_h_reg = RST_IMAGE_HEIGHT;
        ker_w_reg = RST_KERNEL_WIDTH;
        ker_h_reg = RST_KERNEL_HEIGHT;
        in_row_n = 0;
        in_col_n = 0;
        out_row_n = 0;
        out_col_n = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_frame();
        test_kernel_shapes();
        test_full_width();
        test_random_frames();

        wait_idle();
        if (!failed)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
